>>> src/desa_pkg.sv
`timescale 1ns / 1ps
package desa_pkg;

   localparam int TABLE_SLOTS = 2048;

   localparam int CMD_W = 4;
   localparam int BYTES_W = 28;
   localparam int ID_W = 11;
   localparam int ADDR_W = 32;
   // a rounded request is at most 2^28, one bit wider than the request
   localparam int SIZE_W = BYTES_W + 1;
   localparam int GRANULE_BITS = 4;
   localparam int CSR_ADDR_W = 3;

   localparam logic [ADDR_W-1:0] RESET_BASE = 32'd0;
   localparam logic [ADDR_W-1:0] RESET_BYTES = 32'd25690112;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC_BOTTOM = 4'd0,
      CMD_ALLOC_TOP    = 4'd1,
      CMD_FREE_BOTTOM  = 4'd2,
      CMD_FREE_TOP     = 4'd3,
      CMD_CLEAR_ALL    = 4'd4,
      CMD_CLEAR_BOTTOM = 4'd5,
      CMD_CLEAR_TOP    = 4'd6,
      CMD_BOTTOM_ADDR  = 4'd7,
      CMD_BOTTOM_SIZE  = 4'd8,
      CMD_TOP_ADDR     = 4'd9,
      CMD_TOP_SIZE     = 4'd10,
      CMD_NEXT_BOTTOM  = 4'd11,
      CMD_NEXT_TOP     = 4'd12
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ID_RANGE   = 2'd1,
      ST_NO_SPACE   = 2'd2,
      ST_TABLE_FULL = 2'd3
   } status_type;

   typedef enum logic {
      REG_REGION_BASE  = 1'b0,
      REG_REGION_BYTES = 1'b1
   } reg_type;

   // one block of either end: its outer edge (start for bottom, upper edge for top)
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } end_entry_type;

   typedef struct packed {
      logic              alloc;
      logic              pop;
      logic              clear;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] next_addr;
   } end_upd_type;

endpackage

>>> src/desa_csr.sv
`timescale 1ns / 1ps
module desa_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [desa_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready,
   output logic [desa_pkg::ADDR_W-1:0]            region_base,
   output logic [desa_pkg::ADDR_W-1:0]            region_bytes
);

   logic [desa_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [desa_pkg::ADDR_W-1:0] bytes_ff, bytes_in;
   logic                        wr;
   desa_pkg::reg_type           sel;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign sel = desa_pkg::reg_type'(paddr[2]);

   always_comb begin
      base_in = base_ff;
      bytes_in = bytes_ff;
      prdata = '0;
      unique case (sel)
         desa_pkg::REG_REGION_BASE: begin
            prdata = base_ff;
            if (wr) base_in = pwdata;
         end
         desa_pkg::REG_REGION_BYTES: begin
            prdata = bytes_ff;
            if (wr) bytes_in = pwdata;
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= desa_pkg::RESET_BASE;
         bytes_ff <= desa_pkg::RESET_BYTES;
      end else begin
         base_ff <= base_in;
         bytes_ff <= bytes_in;
      end
   end

   assign region_base = base_ff;
   assign region_bytes = bytes_ff;

endmodule

>>> src/desa_end.sv
`timescale 1ns / 1ps
module desa_end #(
   parameter int SLOTS = desa_pkg::TABLE_SLOTS,
   localparam int AW = $clog2(SLOTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_idx,
   input  desa_pkg::end_upd_type         upd,
   input  logic [desa_pkg::ADDR_W-1:0]   clear_addr,
   output logic [AW-1:0]                 count,
   output logic [desa_pkg::ADDR_W-1:0]   next_addr,
   output desa_pkg::end_entry_type       entry
);

   desa_pkg::end_entry_type mem [SLOTS];

   logic [AW-1:0]               count_ff, count_in;
   logic [desa_pkg::ADDR_W-1:0] next_ff, next_in;
   logic [desa_pkg::ADDR_W-1:0] last_ff, last_in;   // outer edge of the newest block
   logic [desa_pkg::ADDR_W-1:0] prev_ff;            // outer edge of the block below it
   logic [AW-1:0]               prev_idx;
   logic                        wr_en;
   desa_pkg::end_entry_type     wdata;
   desa_pkg::end_entry_type     rd_ff;
   desa_pkg::end_entry_type     byp_ff;
   logic                        hit_ff;

   assign wdata = '{addr: upd.addr, size: upd.size};

   always_comb begin
      count_in = count_ff;
      next_in = next_ff;
      last_in = last_ff;
      wr_en = 1'b0;
      if (reset || upd.clear) begin
         count_in = '0;
         next_in = clear_addr;
      end else if (upd.alloc) begin
         wr_en = 1'b1;
         count_in = count_ff + AW'(1);
         next_in = upd.next_addr;
         last_in = upd.addr;
      end else if (upd.pop && count_ff != '0) begin
         count_in = count_ff - AW'(1);
         next_in = last_ff;
         last_in = prev_ff;
      end
   end

   // prefetch so that a pop in the following cycle finds its new last edge ready
   assign prev_idx = count_in - AW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      next_ff <= next_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff] <= wdata;
      end
      prev_ff <= mem[prev_idx].addr;
      if (rd_en) begin
         rd_ff <= mem[rd_idx];
         hit_ff <= wr_en && (count_ff == rd_idx);
         byp_ff <= wdata;
      end
   end

   assign count = count_ff;
   assign next_addr = next_ff;
   assign entry = hit_ff ? byp_ff : rd_ff;

endmodule

>>> src/double_ended_stack_allocator.sv
`timescale 1ns / 1ps
// Double-ended stack allocator: one command word per cycle while req_stall is low, and
// every command gives exactly one result word, in order. Bottom blocks grow upward from
// region_base, top blocks downward from region_base + region_bytes, sizes rounded up to
// 16 bytes. Each end keeps its next free address and newest block in registers and its
// blocks in a memory; the block query is read from that memory in the cycle a command is
// taken. Region registers take effect at the next clear or reset.
module double_ended_stack_allocator #(
   parameter int TABLE_SLOTS = desa_pkg::TABLE_SLOTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [desa_pkg::CMD_W-1:0]           req_cmd,
   input  logic [desa_pkg::BYTES_W-1:0]         req_request_bytes,
   input  logic [desa_pkg::ID_W-1:0]            req_block_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [desa_pkg::ADDR_W-1:0]          rsp_value,
   output logic [1:0]                           rsp_status,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [desa_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam int AW = $clog2(TABLE_SLOTS);

   logic [desa_pkg::ADDR_W-1:0] region_base, region_bytes;
   logic [desa_pkg::ADDR_W-1:0] clr_bottom, clr_top;

   logic                         s1_valid_ff, s1_valid_in;
   desa_pkg::cmd_type            s1_cmd_ff;
   logic [desa_pkg::BYTES_W-1:0] s1_bytes_ff;
   logic [desa_pkg::ID_W-1:0]    s1_id_ff;
   logic                         accept, advance;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [desa_pkg::ADDR_W-1:0]  rsp_value_ff, rsp_value_in;
   desa_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic [AW-1:0]                count_b, count_t;
   logic [desa_pkg::ADDR_W-1:0]  next_b, next_t;
   desa_pkg::end_entry_type      ent_b, ent_t;
   desa_pkg::end_upd_type        upd_b, upd_t;

   logic [desa_pkg::SIZE_W-1:0]   bytes_sum;
   logic [desa_pkg::SIZE_W-1:0]   rounded;
   logic [desa_pkg::ADDR_W:0]     end_b;
   logic [desa_pkg::ADDR_W:0]     start_t;
   logic [AW:0]                   used;
   logic                          full, nospace_b, nospace_t;
   logic                          id_bad_b, id_bad_t;

   desa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .region_base  (region_base),
      .region_bytes (region_bytes)
   );

   // reset behaves as clear all with the reset values of the region registers
   assign clr_bottom = reset ? desa_pkg::RESET_BASE : region_base;
   assign clr_top = reset ? desa_pkg::RESET_BASE + desa_pkg::RESET_BYTES
                          : region_base + region_bytes;

   // handshake
   assign advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_cmd_ff <= desa_pkg::cmd_type'(req_cmd);
         s1_bytes_ff <= req_request_bytes;
         s1_id_ff <= req_block_id;
      end
      if (advance) begin
         rsp_value_ff <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   desa_end #(.SLOTS(TABLE_SLOTS)) u_bottom (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_idx     (AW'(req_block_id)),
      .upd        (upd_b),
      .clear_addr (clr_bottom),
      .count      (count_b),
      .next_addr  (next_b),
      .entry      (ent_b)
   );

   desa_end #(.SLOTS(TABLE_SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_idx     (AW'(req_block_id)),
      .upd        (upd_t),
      .clear_addr (clr_top),
      .count      (count_t),
      .next_addr  (next_t),
      .entry      (ent_t)
   );

   // round up to the 16-byte granule
   assign bytes_sum = {1'b0, s1_bytes_ff} + desa_pkg::SIZE_W'(15);
   assign rounded = {bytes_sum[desa_pkg::SIZE_W-1:desa_pkg::GRANULE_BITS],
                     {desa_pkg::GRANULE_BITS{1'b0}}};

   assign used = {1'b0, count_b} + {1'b0, count_t} + (AW+1)'(2);
   assign full = used >= (AW+1)'(TABLE_SLOTS);

   assign end_b = {1'b0, next_b} + (desa_pkg::ADDR_W+1)'(rounded);
   assign nospace_b = end_b > {1'b0, next_t};
   assign start_t = {1'b0, next_t} - (desa_pkg::ADDR_W+1)'(rounded);
   assign nospace_t = start_t[desa_pkg::ADDR_W] || (start_t[desa_pkg::ADDR_W-1:0] < next_b);

   assign id_bad_b = 32'(s1_id_ff) >= 32'(count_b);
   assign id_bad_t = 32'(s1_id_ff) >= 32'(count_t);

   always_comb begin
      upd_b = '0;
      upd_t = '0;
      upd_b.addr = next_b;
      upd_b.size = rounded;
      upd_b.next_addr = end_b[desa_pkg::ADDR_W-1:0];
      upd_t.addr = next_t;
      upd_t.size = rounded;
      upd_t.next_addr = start_t[desa_pkg::ADDR_W-1:0];
      rsp_value_in = '0;
      rsp_status_in = desa_pkg::ST_OK;
      unique case (s1_cmd_ff) inside
         desa_pkg::CMD_ALLOC_BOTTOM: begin
            if (full) begin
               rsp_status_in = desa_pkg::ST_TABLE_FULL;
            end else if (nospace_b) begin
               rsp_status_in = desa_pkg::ST_NO_SPACE;
            end else begin
               upd_b.alloc = advance;
               rsp_value_in = next_b;
            end
         end
         desa_pkg::CMD_ALLOC_TOP: begin
            if (full) begin
               rsp_status_in = desa_pkg::ST_TABLE_FULL;
            end else if (nospace_t) begin
               rsp_status_in = desa_pkg::ST_NO_SPACE;
            end else begin
               upd_t.alloc = advance;
               rsp_value_in = start_t[desa_pkg::ADDR_W-1:0];
            end
         end
         desa_pkg::CMD_FREE_BOTTOM: upd_b.pop = advance;
         desa_pkg::CMD_FREE_TOP:    upd_t.pop = advance;
         desa_pkg::CMD_CLEAR_ALL: begin
            upd_b.clear = advance;
            upd_t.clear = advance;
         end
         desa_pkg::CMD_CLEAR_BOTTOM: upd_b.clear = advance;
         desa_pkg::CMD_CLEAR_TOP:    upd_t.clear = advance;
         desa_pkg::CMD_BOTTOM_ADDR, desa_pkg::CMD_BOTTOM_SIZE: begin
            if (id_bad_b) begin
               rsp_status_in = desa_pkg::ST_ID_RANGE;
            end else if (s1_cmd_ff == desa_pkg::CMD_BOTTOM_ADDR) begin
               rsp_value_in = ent_b.addr;
            end else begin
               rsp_value_in = desa_pkg::ADDR_W'(ent_b.size);
            end
         end
         desa_pkg::CMD_TOP_ADDR, desa_pkg::CMD_TOP_SIZE: begin
            if (id_bad_t) begin
               rsp_status_in = desa_pkg::ST_ID_RANGE;
            end else if (s1_cmd_ff == desa_pkg::CMD_TOP_ADDR) begin
               rsp_value_in = ent_t.addr;
            end else begin
               rsp_value_in = desa_pkg::ADDR_W'(ent_t.size);
            end
         end
         desa_pkg::CMD_NEXT_BOTTOM: rsp_value_in = next_b;
         desa_pkg::CMD_NEXT_TOP:    rsp_value_in = next_t;
         default: rsp_value_in = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> tb/double_ended_stack_allocator_tb.sv
`timescale 1ns / 1ps
module double_ended_stack_allocator_tb;
   import desa_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 4'd13;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 4'd15;
   localparam int HALF_PERIOD_NS = 6;
   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_PLANS = 7;
   localparam int PLAN_WORDS = 150;

   // Shadow allocator plus the queue of result words still owed by the block.
   class alloc_scoreboard;
      logic [ADDR_W-1:0] edges [TABLE_SLOTS];
      int unsigned n_bottom;
      int unsigned n_top;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] span;
      logic [ADDR_W-1:0] due_value [$];
      status_type due_status [$];
      int unsigned status_seen [4];
      int unsigned mismatches;
      int unsigned words_checked;

      function new();
         base = RESET_BASE;
         span = RESET_BYTES;
         foreach (edges[i]) edges[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
         wipe_bottom();
         wipe_top();
         mismatches = 0;
         words_checked = 0;
      endfunction

      function void wipe_bottom();
         n_bottom = 0;
         edges[0] = base;
      endfunction

      function void wipe_top();
         n_top = 0;
         edges[TABLE_SLOTS-1] = base + span;
      endfunction

      function bit is_full();
         return n_bottom + n_top + 2 >= TABLE_SLOTS;
      endfunction

      function int unsigned pending();
         return due_value.size();
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
      endfunction

      function void note_command(logic [CMD_W-1:0] cmd, logic [BYTES_W-1:0] nbytes,
                                 logic [ID_W-1:0] id);
         logic [ADDR_W:0] rounded;
         logic [ADDR_W:0] lo;
         logic [ADDR_W:0] hi;
         logic [ADDR_W-1:0] value;
         status_type status;
         int unsigned slot;
         rounded = ((ADDR_W+1)'(nbytes) + (ADDR_W+1)'(2**GRANULE_BITS - 1))
                   >> GRANULE_BITS << GRANULE_BITS;
         lo = {1'b0, edges[n_bottom]};
         hi = {1'b0, edges[TABLE_SLOTS-1-n_top]};
         value = '0;
         status = ST_OK;
         case (cmd) inside
            CMD_ALLOC_BOTTOM: begin
               if (is_full()) status = ST_TABLE_FULL;
               else if (lo + rounded > hi) status = ST_NO_SPACE;
               else begin
                  n_bottom++;
                  edges[n_bottom] = ADDR_W'(lo + rounded);
                  value = lo[ADDR_W-1:0];
               end
            end
            CMD_ALLOC_TOP: begin
               if (is_full()) status = ST_TABLE_FULL;
               else if (rounded > hi || hi - rounded < lo) status = ST_NO_SPACE;
               else begin
                  n_top++;
                  value = ADDR_W'(hi - rounded);
                  edges[TABLE_SLOTS-1-n_top] = value;
               end
            end
            CMD_FREE_BOTTOM: if (n_bottom != 0) n_bottom--;
            CMD_FREE_TOP: if (n_top != 0) n_top--;
            CMD_CLEAR_ALL: begin
               wipe_bottom();
               wipe_top();
            end
            CMD_CLEAR_BOTTOM: wipe_bottom();
            CMD_CLEAR_TOP: wipe_top();
            CMD_BOTTOM_ADDR, CMD_BOTTOM_SIZE: begin
               if (id >= n_bottom) status = ST_ID_RANGE;
               else if (cmd == CMD_BOTTOM_ADDR) value = edges[id];
               else value = edges[id + 1] - edges[id];
            end
            CMD_TOP_ADDR, CMD_TOP_SIZE: begin
               slot = TABLE_SLOTS - 1 - id;
               if (id >= n_top) status = ST_ID_RANGE;
               else if (cmd == CMD_TOP_ADDR) value = edges[slot];
               else value = edges[slot] - edges[slot-1];
            end
            CMD_NEXT_BOTTOM: value = lo[ADDR_W-1:0];
            CMD_NEXT_TOP: value = hi[ADDR_W-1:0];
            default: ;
         endcase
         status_seen[status]++;
         due_value.push_back(value);
         due_status.push_back(status);
      endfunction

      function void check_result(logic [ADDR_W-1:0] value, logic [1:0] status);
         logic [ADDR_W-1:0] want_value;
         status_type want_status;
         words_checked++;
         if (due_value.size() == 0) begin
            flag($sformatf("unexpected word: value %h status %0d", value, status));
            return;
         end
         want_value = due_value.pop_front();
         want_status = due_status.pop_front();
         if (value !== want_value || status !== want_status)
            flag($sformatf("value %h status %0d, expected value %h status %0d",
                           value, status, want_value, want_status));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [CMD_W-1:0] req_cmd = '0;
   logic [BYTES_W-1:0] req_request_bytes = '0;
   logic [ID_W-1:0] req_block_id = '0;
   logic rsp_stall = 1'b0;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic req_stall;
   logic rsp_valid;
   logic [ADDR_W-1:0] rsp_value;
   logic [1:0] rsp_status;
   logic [31:0] prdata;
   logic pready;

   alloc_scoreboard board = new();
   int unsigned send_idle_pct = 20;
   int unsigned recv_stall_pct = 76;
   int unsigned words_sent = 0;

   double_ended_stack_allocator u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_request_bytes(req_request_bytes),
      .req_block_id(req_block_id),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_status(rsp_status),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #(HALF_PERIOD_NS) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) board.check_result(rsp_value, rsp_status);
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_word(logic [CMD_W-1:0] cmd, logic [BYTES_W-1:0] nbytes,
                            logic [ID_W-1:0] id);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_request_bytes <= nbytes;
      req_block_id <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_command(cmd, nbytes, id);
      words_sent++;
   endtask

   task automatic random_word();
      int unsigned pick;
      logic [CMD_W-1:0] cmd;
      logic [BYTES_W-1:0] nbytes;
      logic [ID_W-1:0] id;
      pick = $urandom_range(99);
      if (pick < 22) cmd = CMD_ALLOC_BOTTOM;
      else if (pick < 44) cmd = CMD_ALLOC_TOP;
      else if (pick < 52) cmd = CMD_FREE_BOTTOM;
      else if (pick < 60) cmd = CMD_FREE_TOP;
      else if (pick < 61) cmd = CMD_CLEAR_ALL;
      else if (pick < 62) cmd = CMD_CLEAR_BOTTOM;
      else if (pick < 63) cmd = CMD_CLEAR_TOP;
      else if (pick < 71) cmd = CMD_BOTTOM_ADDR;
      else if (pick < 79) cmd = CMD_BOTTOM_SIZE;
      else if (pick < 86) cmd = CMD_TOP_ADDR;
      else if (pick < 93) cmd = CMD_TOP_SIZE;
      else if (pick < 95) cmd = CMD_NEXT_BOTTOM;
      else if (pick < 97) cmd = CMD_NEXT_TOP;
      else cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      // random shift spreads sizes evenly over the orders of magnitude
      nbytes = BYTES_W'($urandom >> $urandom_range(ADDR_W - BYTES_W, ADDR_W - 1));
      id = ID_W'($urandom);
      if ($urandom_range(9) != 0) begin
         if (cmd == CMD_BOTTOM_ADDR || cmd == CMD_BOTTOM_SIZE)
            id = ID_W'($urandom_range(0, board.n_bottom));
         else if (cmd == CMD_TOP_ADDR || cmd == CMD_TOP_SIZE)
            id = ID_W'($urandom_range(0, board.n_top));
      end
      send_word(cmd, nbytes, id);
   endtask

   // let the block go quiet before touching the region registers
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_region(reg_type which, logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {which, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== v)
         board.flag($sformatf("register %0d reads %h, written %h", which, prdata, v));
      psel <= 1'b0;
      penable <= 1'b0;
      if (which == REG_REGION_BASE) board.base = v;
      else board.span = v;
   endtask

   initial begin
      #(5_000_000);
      $display("Run did not finish in time");
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [31:0] plan_base [NUM_PLANS];
      logic [31:0] plan_span [NUM_PLANS];
      plan_base = '{32'h0000_0000, 32'h1000_0000, 32'hFFFF_F000, 32'hFFFF_FFFF,
                    32'h0000_0000, 32'h0, 32'h0000_0100};
      plan_span = '{32'hFFFF_FFFF, 32'h0000_2000, 32'h0000_2000, 32'h0000_0000,
                    32'h0000_0000, 32'h0, 32'h0100_0000};
      plan_base[5] = $urandom;
      plan_span[5] = $urandom >> $urandom_range(0, 8);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words against the reset region
      send_word(CMD_NEXT_BOTTOM, '0, '0);
      send_word(CMD_NEXT_TOP, '0, '0);
      send_word(CMD_FREE_BOTTOM, '0, '0);
      send_word(CMD_FREE_TOP, '0, '0);
      send_word(CMD_BOTTOM_ADDR, '0, '0);
      send_word(CMD_TOP_SIZE, '0, '1);
      send_word(CMD_ALLOC_BOTTOM, '0, '0);
      send_word(CMD_ALLOC_BOTTOM, 28'd1, '0);
      send_word(CMD_ALLOC_BOTTOM, 28'd17, '0);
      send_word(CMD_ALLOC_TOP, 28'd16, '0);
      send_word(CMD_ALLOC_TOP, '1, '1);
      send_word(CMD_ALLOC_BOTTOM, '1, '0);
      send_word(CMD_BOTTOM_ADDR, 11'd2, 11'd2);
      send_word(CMD_BOTTOM_SIZE, '0, 11'd1);
      send_word(CMD_BOTTOM_SIZE, '0, 11'd3);
      send_word(CMD_TOP_ADDR, '0, '0);
      send_word(CMD_TOP_SIZE, '0, '0);
      send_word(CMD_NEXT_BOTTOM, '1, '1);
      send_word(CMD_NEXT_TOP, '0, '0);
      send_word(CMD_SPARE_FIRST, '1, '1);
      send_word(CMD_SPARE_LAST, '0, '0);
      send_word(CMD_FREE_BOTTOM, '0, '0);
      send_word(CMD_CLEAR_BOTTOM, '0, '0);
      send_word(CMD_CLEAR_TOP, '0, '0);
      send_word(CMD_CLEAR_ALL, '0, '0);

      for (int k = 0; k < NUM_PLANS; k++) begin
         settle();
         if (k < 3) begin
            send_idle_pct = 20;
            recv_stall_pct = 76;
         end else if (k < NUM_PLANS - 1) begin
            send_idle_pct = 76;
            recv_stall_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         write_region(REG_REGION_BASE, plan_base[k]);
         write_region(REG_REGION_BYTES, plan_span[k]);
         send_word(CMD_CLEAR_ALL, '0, '0);
         repeat (PLAN_WORDS) random_word();
      end

      // empty ends of a fresh region: queries at and past the counts, pops and small blocks
      send_word(CMD_CLEAR_ALL, '0, '0);
      send_word(CMD_ALLOC_BOTTOM, '0, '0);
      send_word(CMD_ALLOC_TOP, '1, '0);
      send_word(CMD_BOTTOM_SIZE, '0, ID_W'(board.n_bottom - 1));
      send_word(CMD_BOTTOM_ADDR, '0, ID_W'(board.n_bottom));
      send_word(CMD_TOP_ADDR, '0, ID_W'(board.n_top - 1));
      send_word(CMD_TOP_SIZE, '0, '1);
      send_word(CMD_FREE_BOTTOM, '0, '0);
      send_word(CMD_ALLOC_TOP, 28'd5, '0);
      send_word(CMD_ALLOC_BOTTOM, 28'd5, '0);
      repeat (60) random_word();
      send_word(CMD_CLEAR_ALL, '0, '0);

      settle();
      $display("Sent %0d command words over %0d region settings and a closing burst.",
               words_sent, NUM_PLANS);
      $display("Statuses seen: ok %0d, bad id %0d, no space %0d, table full %0d.",
               board.status_seen[ST_OK], board.status_seen[ST_ID_RANGE],
               board.status_seen[ST_NO_SPACE], board.status_seen[ST_TABLE_FULL]);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d words outstanding", board.mismatches, board.pending());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
